// ===== src/assert_macros.svh =====
// Assertion macros shared by the RTL files.
// Included by the modules that carry concurrent checks; depends on nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check a property on every clock edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== src/asps_pkg.sv =====
// Shared types, constants and helpers of the arrive steering block.
// Used by asps_alu and arrive_steering_particle_step; no dependencies.
package asps_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int DAMP_SHIFT    = 16;

   typedef enum logic [1:0] {
      ALU_MUL,
      ALU_DIV,
      ALU_SQRT
   } alu_op_type;

   typedef struct packed {
      logic       start;
      alu_op_type op;
   } alu_req_type;

   typedef struct packed {
      logic        done;
      logic [63:0] result;
   } alu_rsp_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_DIFF,
      S_LSQA,
      S_LSQB,
      S_LROOT,
      S_SPDM,
      S_SPDD,
      S_DESXM,
      S_DESXD,
      S_DESYM,
      S_DESYD,
      S_STEER,
      S_LIMXM,
      S_LIMXD,
      S_LIMYM,
      S_LIMYD,
      S_DAMPXM,
      S_DAMPYM,
      S_MOVE,
      S_OUT
   } state_type;

   typedef enum logic [2:0] {
      REG_DAMPING,
      REG_MAX_SPEED,
      REG_MAX_FORCE,
      REG_SLOW_RADIUS,
      REG_ARENA_WIDTH,
      REG_ARENA_HEIGHT,
      REG_BODY_RADIUS,
      REG_NONE
   } reg_index_type;

   // Clamp an elaboration-time value to 31 bits.
   function automatic logic [30:0] sat31(input longint v);
      logic [30:0] r;
      if (v > longint'(31'h7FFF_FFFF)) r = 31'h7FFF_FFFF;
      else r = v[30:0];
      return r;
   endfunction

   // Magnitude of a 35-bit signed value.
   function automatic logic [34:0] mag35(input logic signed [34:0] v);
      logic [34:0] r;
      r = v[34] ? 35'(-v) : 35'(v);
      return r;
   endfunction

   // Saturate a 35-bit signed value to the 32-bit signed range.
   function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
      logic signed [31:0] r;
      if (v > 35'sh0_7FFF_FFFF) r = 32'sh7FFF_FFFF;
      else if (v < -35'sh0_8000_0000) r = 32'sh8000_0000;
      else r = v[31:0];
      return r;
   endfunction

   // Sign-extend a 32-bit value to 35 bits.
   function automatic logic signed [34:0] sx35(input logic signed [31:0] v);
      logic signed [34:0] r;
      r = {{3{v[31]}}, v};
      return r;
   endfunction

endpackage

// ===== src/asps_alu.sv =====
// Shared serial arithmetic unit: shift-add multiply, restoring divide, square root.
// One bit of the operand (one root digit) per cycle. Depends on asps_pkg.
`include "assert_macros.svh"

module asps_alu (
   input  logic                  clock,
   input  logic                  reset,
   input  asps_pkg::alu_req_type req,
   input  logic [63:0]           opa,
   input  logic [63:0]           opb,
   output asps_pkg::alu_rsp_type rsp
);

   logic                 active_ff, active_in;
   logic                 done_ff, done_in;
   asps_pkg::alu_op_type op_ff, op_in;
   logic [6:0]           cnt_ff, cnt_in;
   logic [63:0]          x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic [63:0]          res_ff, res_in;
   logic [63:0]          rem_sh, root_t;
   logic                 last;

   // Advance one digit per cycle
   always_comb begin
      active_in = active_ff;
      done_in   = 1'b0;
      op_in     = op_ff;
      cnt_in    = cnt_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      z_in      = z_ff;
      res_in    = res_ff;
      rem_sh    = {z_ff[62:0], x_ff[63]};
      root_t    = y_ff + z_ff;
      last      = 1'b0;
      if (req.start) begin
         active_in = 1'b1;
         op_in     = req.op;
         cnt_in    = '0;
         x_in      = opa;
         y_in      = (req.op == asps_pkg::ALU_MUL) ? {32'd0, opb[31:0]} :
                     (req.op == asps_pkg::ALU_DIV) ? opb : 64'd0;
         z_in      = (req.op == asps_pkg::ALU_SQRT) ? (64'd1 << 62) : 64'd0;
      end else if (active_ff) begin
         cnt_in = cnt_ff + 7'd1;
         case (op_ff)
            asps_pkg::ALU_MUL: begin
               z_in = y_ff[0] ? z_ff + x_ff : z_ff;
               x_in = {x_ff[62:0], 1'b0};
               y_in = {1'b0, y_ff[63:1]};
               last = (cnt_ff == 7'd31);
               res_in = z_in;
            end
            asps_pkg::ALU_DIV: begin
               if (rem_sh >= y_ff) begin
                  z_in = rem_sh - y_ff;
                  x_in = {x_ff[62:0], 1'b1};
               end else begin
                  z_in = rem_sh;
                  x_in = {x_ff[62:0], 1'b0};
               end
               last = (cnt_ff == 7'd63);
               res_in = x_in;
            end
            asps_pkg::ALU_SQRT: begin
               if (x_ff >= root_t) begin
                  x_in = x_ff - root_t;
                  y_in = {1'b0, y_ff[63:1]} + z_ff;
               end else begin
                  y_in = {1'b0, y_ff[63:1]};
               end
               z_in = {2'b00, z_ff[63:2]};
               last = (cnt_ff == 7'd31);
               res_in = y_in;
            end
            default: begin
               last = 1'b1;
            end
         endcase
         if (last) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
      end
      op_ff  <= op_in;
      cnt_ff <= cnt_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
      z_ff   <= z_in;
      res_ff <= res_in;
   end

   assign rsp.done   = done_ff;
   assign rsp.result = res_ff;

   `ASSERT_CLK(a_no_restart, clock, reset, active_ff |-> !req.start, "start while busy")
   `ASSERT_CLK(a_start_runs, clock, reset, req.start |=> active_ff, "start did not run")
   `ASSERT_CLK(a_done_pulse, clock, reset, done_ff |=> !done_ff, "done longer than one cycle")

endmodule

// ===== src/arrive_steering_particle_step.sv =====
// Arrive steering for one agent: position and velocity in signed fixed point.
// Top level; depends on asps_pkg and asps_alu.
//
// A load transaction sets position and velocity; its result passes through the
// S_OUT state into the output register.
// A tick transaction runs every multiply, divide and square root on one shared
// serial arithmetic unit. When the agent is at the target it skips the steps for
// the desired velocity; inside the slow-down radius it adds a multiply and a
// divide for the speed, and when the steering passes the force limit it adds two
// multiplies and two divides to scale it down. The block takes the next
// transaction in the cycle after the result moves out.
// One transaction is processed at a time; the result waits on rsp_ in an output
// register, so the next transaction can start while it waits to be taken.
`include "assert_macros.svh"

module arrive_steering_particle_step #(
   parameter int FRAC_BITS = asps_pkg::FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_mode,
   input  logic signed [31:0] req_target_x,
   input  logic signed [31:0] req_target_y,
   input  logic signed [31:0] req_init_pos_x,
   input  logic signed [31:0] req_init_pos_y,
   input  logic signed [31:0] req_init_vel_x,
   input  logic signed [31:0] req_init_vel_y,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_pos_x,
   output logic signed [31:0] rsp_pos_y,
   output logic signed [31:0] rsp_vel_x,
   output logic signed [31:0] rsp_vel_y,
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [30:0]        csr_data
);

   localparam longint ONE_FX = longint'(1) << FRAC_BITS;
   localparam logic [30:0] RST_MAX_SPEED = asps_pkg::sat31(2 * ONE_FX);
   localparam logic [30:0] RST_MAX_FORCE = asps_pkg::sat31((ONE_FX + 5) / 10);
   localparam logic [30:0] RST_SLOW_RAD  = asps_pkg::sat31(10 * ONE_FX);
   localparam logic [30:0] RST_ARENA_W   = asps_pkg::sat31(1024 * ONE_FX);
   localparam logic [30:0] RST_ARENA_H   = asps_pkg::sat31(768 * ONE_FX);
   localparam logic [30:0] RST_BODY      = asps_pkg::sat31(ONE_FX);
   localparam logic [16:0] RST_DAMPING   = 17'd62259;

   // Configuration registers
   logic [16:0] damping_ff;
   logic [30:0] max_speed_ff, max_force_ff, slow_radius_ff;
   logic [30:0] arena_w_ff, arena_h_ff, body_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         damping_ff     <= RST_DAMPING;
         max_speed_ff   <= RST_MAX_SPEED;
         max_force_ff   <= RST_MAX_FORCE;
         slow_radius_ff <= RST_SLOW_RAD;
         arena_w_ff     <= RST_ARENA_W;
         arena_h_ff     <= RST_ARENA_H;
         body_ff        <= RST_BODY;
      end else if (csr_we) begin
         case (asps_pkg::reg_index_type'(csr_index))
            asps_pkg::REG_DAMPING:      damping_ff     <= csr_data[16:0];
            asps_pkg::REG_MAX_SPEED:    max_speed_ff   <= csr_data;
            asps_pkg::REG_MAX_FORCE:    max_force_ff   <= csr_data;
            asps_pkg::REG_SLOW_RADIUS:  slow_radius_ff <= csr_data;
            asps_pkg::REG_ARENA_WIDTH:  arena_w_ff     <= csr_data;
            asps_pkg::REG_ARENA_HEIGHT: arena_h_ff     <= csr_data;
            asps_pkg::REG_BODY_RADIUS:  body_ff        <= csr_data;
            default: ;
         endcase
      end
   end

   asps_pkg::state_type state_ff, state_in;
   logic signed [31:0]  pos_x_ff, pos_x_in, pos_y_ff, pos_y_in;
   logic signed [31:0]  vel_x_ff, vel_x_in, vel_y_ff, vel_y_in;
   logic signed [31:0]  tgt_x_ff, tgt_x_in, tgt_y_ff, tgt_y_in;
   logic signed [31:0]  vx_ff, vx_in, vy_ff, vy_in;
   logic signed [34:0]  dx_ff, dx_in, dy_ff, dy_in;
   logic signed [34:0]  st_x_ff, st_x_in, st_y_ff, st_y_in;
   logic [63:0]         sum_ff, sum_in, prod_ff, prod_in;
   logic [34:0]         len_ff, len_in;
   logic [30:0]         speed_ff, speed_in;
   logic                phase_ff, phase_in;
   logic                wait_ff, wait_in;
   logic                out_valid_ff, out_valid_in;
   logic signed [31:0]  out_pos_x_ff, out_pos_x_in, out_pos_y_ff, out_pos_y_in;
   logic signed [31:0]  out_vel_x_ff, out_vel_x_in, out_vel_y_ff, out_vel_y_in;

   asps_pkg::alu_req_type alu_req;
   asps_pkg::alu_rsp_type alu_rsp;
   logic [63:0]           alu_a, alu_b;

   logic [34:0]        mag_a, mag_b, len_root;
   logic [31:0]        sh_a, sh_b;
   logic               len_shift;
   logic signed [34:0] w_x, w_y, q_sig, damp_q;
   logic               is_op;

   asps_alu u_alu (
      .clock (clock),
      .reset (reset),
      .req   (alu_req),
      .opa   (alu_a),
      .opb   (alu_b),
      .rsp   (alu_rsp)
   );

   // Vector length operands: halve both when either reaches 2^31
   always_comb begin
      mag_a     = asps_pkg::mag35(phase_ff ? st_x_ff : dx_ff);
      mag_b     = asps_pkg::mag35(phase_ff ? st_y_ff : dy_ff);
      len_shift = (mag_a[34:31] != 4'd0) || (mag_b[34:31] != 4'd0);
      sh_a      = len_shift ? mag_a[32:1] : mag_a[31:0];
      sh_b      = len_shift ? mag_b[32:1] : mag_b[31:0];
      len_root  = len_shift ? {alu_rsp.result[33:0], 1'b0} : alu_rsp.result[34:0];
      w_x       = asps_pkg::sx35(vel_x_ff) + st_x_ff;
      w_y       = asps_pkg::sx35(vel_y_ff) + st_y_ff;
   end

   // Select unit operation and operands for the current step
   always_comb begin
      is_op = 1'b1;
      alu_req.op = asps_pkg::ALU_MUL;
      alu_a = 64'd0;
      alu_b = 64'd0;
      case (state_ff)
         asps_pkg::S_LSQA: begin
            alu_a = {32'd0, sh_a};
            alu_b = {32'd0, sh_a};
         end
         asps_pkg::S_LSQB: begin
            alu_a = {32'd0, sh_b};
            alu_b = {32'd0, sh_b};
         end
         asps_pkg::S_LROOT: begin
            alu_req.op = asps_pkg::ALU_SQRT;
            alu_a = sum_ff;
         end
         asps_pkg::S_SPDM: begin
            alu_a = {29'd0, len_ff};
            alu_b = {33'd0, max_speed_ff};
         end
         asps_pkg::S_SPDD: begin
            alu_req.op = asps_pkg::ALU_DIV;
            alu_a = prod_ff;
            alu_b = {33'd0, slow_radius_ff};
         end
         asps_pkg::S_DESXM: begin
            alu_a = {29'd0, asps_pkg::mag35(dx_ff)};
            alu_b = {33'd0, speed_ff};
         end
         asps_pkg::S_DESYM: begin
            alu_a = {29'd0, asps_pkg::mag35(dy_ff)};
            alu_b = {33'd0, speed_ff};
         end
         asps_pkg::S_LIMXM: begin
            alu_a = {29'd0, asps_pkg::mag35(st_x_ff)};
            alu_b = {33'd0, max_force_ff};
         end
         asps_pkg::S_LIMYM: begin
            alu_a = {29'd0, asps_pkg::mag35(st_y_ff)};
            alu_b = {33'd0, max_force_ff};
         end
         asps_pkg::S_DESXD, asps_pkg::S_DESYD, asps_pkg::S_LIMXD, asps_pkg::S_LIMYD: begin
            alu_req.op = asps_pkg::ALU_DIV;
            alu_a = prod_ff;
            alu_b = {29'd0, len_ff};
         end
         asps_pkg::S_DAMPXM: begin
            alu_a = {29'd0, asps_pkg::mag35(w_x)};
            alu_b = {47'd0, damping_ff};
         end
         asps_pkg::S_DAMPYM: begin
            alu_a = {29'd0, asps_pkg::mag35(w_y)};
            alu_b = {47'd0, damping_ff};
         end
         default: is_op = 1'b0;
      endcase
      alu_req.start = is_op && !wait_ff;
   end

   // Next state and datapath updates
   always_comb begin
      logic signed [34:0] np_x, np_y, lo, hi_x, hi_y;
      logic               out_x, out_y;
      state_in = state_ff;
      pos_x_in = pos_x_ff;
      pos_y_in = pos_y_ff;
      vel_x_in = vel_x_ff;
      vel_y_in = vel_y_ff;
      tgt_x_in = tgt_x_ff;
      tgt_y_in = tgt_y_ff;
      vx_in    = vx_ff;
      vy_in    = vy_ff;
      dx_in    = dx_ff;
      dy_in    = dy_ff;
      st_x_in  = st_x_ff;
      st_y_in  = st_y_ff;
      sum_in   = sum_ff;
      prod_in  = prod_ff;
      len_in   = len_ff;
      speed_in = speed_ff;
      phase_in = phase_ff;
      wait_in  = wait_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      out_pos_x_in = out_pos_x_ff;
      out_pos_y_in = out_pos_y_ff;
      out_vel_x_in = out_vel_x_ff;
      out_vel_y_in = out_vel_y_ff;
      q_sig    = 35'(alu_rsp.result[34:0]);
      damp_q   = 35'(alu_rsp.result[34 + asps_pkg::DAMP_SHIFT:asps_pkg::DAMP_SHIFT]);
      lo       = {4'd0, body_ff};
      hi_x     = {4'd0, arena_w_ff} - {4'd0, body_ff};
      hi_y     = {4'd0, arena_h_ff} - {4'd0, body_ff};
      np_x     = asps_pkg::sx35(asps_pkg::sat32(asps_pkg::sx35(pos_x_ff) +
                                                 asps_pkg::sx35(vx_ff)));
      np_y     = asps_pkg::sx35(asps_pkg::sat32(asps_pkg::sx35(pos_y_ff) +
                                                 asps_pkg::sx35(vy_ff)));
      out_x    = (np_x < lo) || (np_x > hi_x);
      out_y    = (np_y < lo) || (np_y > hi_y);

      if (alu_req.start) wait_in = 1'b1;
      if (alu_rsp.done) wait_in = 1'b0;

      case (state_ff)
         asps_pkg::S_IDLE: begin
            if (req_valid) begin
               if (req_mode) begin
                  pos_x_in = req_init_pos_x;
                  pos_y_in = req_init_pos_y;
                  vel_x_in = req_init_vel_x;
                  vel_y_in = req_init_vel_y;
                  state_in = asps_pkg::S_OUT;
               end else begin
                  tgt_x_in = req_target_x;
                  tgt_y_in = req_target_y;
                  state_in = asps_pkg::S_DIFF;
               end
            end
         end
         asps_pkg::S_DIFF: begin
            dx_in    = asps_pkg::sx35(tgt_x_ff) - asps_pkg::sx35(pos_x_ff);
            dy_in    = asps_pkg::sx35(tgt_y_ff) - asps_pkg::sx35(pos_y_ff);
            phase_in = 1'b0;
            state_in = asps_pkg::S_LSQA;
         end
         asps_pkg::S_LSQA: if (alu_rsp.done) begin
            sum_in   = alu_rsp.result;
            state_in = asps_pkg::S_LSQB;
         end
         asps_pkg::S_LSQB: if (alu_rsp.done) begin
            sum_in   = sum_ff + alu_rsp.result;
            state_in = asps_pkg::S_LROOT;
         end
         asps_pkg::S_LROOT: if (alu_rsp.done) begin
            len_in = len_root;
            if (!phase_ff) begin
               if (len_root == 35'd0) begin
                  st_x_in  = '0;
                  st_y_in  = '0;
                  state_in = asps_pkg::S_STEER;
               end else if (len_root < {4'd0, slow_radius_ff}) begin
                  state_in = asps_pkg::S_SPDM;
               end else begin
                  speed_in = max_speed_ff;
                  state_in = asps_pkg::S_DESXM;
               end
            end else if (len_root > {4'd0, max_force_ff}) begin
               state_in = asps_pkg::S_LIMXM;
            end else begin
               state_in = asps_pkg::S_DAMPXM;
            end
         end
         asps_pkg::S_SPDM: if (alu_rsp.done) begin
            prod_in  = alu_rsp.result;
            state_in = asps_pkg::S_SPDD;
         end
         asps_pkg::S_SPDD: if (alu_rsp.done) begin
            speed_in = alu_rsp.result[30:0];
            state_in = asps_pkg::S_DESXM;
         end
         asps_pkg::S_DESXM: if (alu_rsp.done) begin
            prod_in  = alu_rsp.result;
            state_in = asps_pkg::S_DESXD;
         end
         asps_pkg::S_DESXD: if (alu_rsp.done) begin
            st_x_in  = dx_ff[34] ? -q_sig : q_sig;
            state_in = asps_pkg::S_DESYM;
         end
         asps_pkg::S_DESYM: if (alu_rsp.done) begin
            prod_in  = alu_rsp.result;
            state_in = asps_pkg::S_DESYD;
         end
         asps_pkg::S_DESYD: if (alu_rsp.done) begin
            st_y_in  = dy_ff[34] ? -q_sig : q_sig;
            state_in = asps_pkg::S_STEER;
         end
         asps_pkg::S_STEER: begin
            st_x_in  = st_x_ff - asps_pkg::sx35(vel_x_ff);
            st_y_in  = st_y_ff - asps_pkg::sx35(vel_y_ff);
            phase_in = 1'b1;
            state_in = asps_pkg::S_LSQA;
         end
         asps_pkg::S_LIMXM: if (alu_rsp.done) begin
            prod_in  = alu_rsp.result;
            state_in = asps_pkg::S_LIMXD;
         end
         asps_pkg::S_LIMXD: if (alu_rsp.done) begin
            st_x_in  = st_x_ff[34] ? -q_sig : q_sig;
            state_in = asps_pkg::S_LIMYM;
         end
         asps_pkg::S_LIMYM: if (alu_rsp.done) begin
            prod_in  = alu_rsp.result;
            state_in = asps_pkg::S_LIMYD;
         end
         asps_pkg::S_LIMYD: if (alu_rsp.done) begin
            st_y_in  = st_y_ff[34] ? -q_sig : q_sig;
            state_in = asps_pkg::S_DAMPXM;
         end
         asps_pkg::S_DAMPXM: if (alu_rsp.done) begin
            vx_in    = asps_pkg::sat32(w_x[34] ? -damp_q : damp_q);
            state_in = asps_pkg::S_DAMPYM;
         end
         asps_pkg::S_DAMPYM: if (alu_rsp.done) begin
            vy_in    = asps_pkg::sat32(w_y[34] ? -damp_q : damp_q);
            state_in = asps_pkg::S_MOVE;
         end
         // Step the position, or bounce off the arena band
         asps_pkg::S_MOVE: begin
            if (out_x) begin
               vel_x_in = asps_pkg::sat32(-asps_pkg::sx35(vx_ff));
            end else begin
               pos_x_in = np_x[31:0];
               vel_x_in = vx_ff;
            end
            if (out_y) begin
               vel_y_in = asps_pkg::sat32(-asps_pkg::sx35(vy_ff));
            end else begin
               pos_y_in = np_y[31:0];
               vel_y_in = vy_ff;
            end
            state_in = asps_pkg::S_OUT;
         end
         // Move the result to the output register once it is free
         asps_pkg::S_OUT: begin
            if (!out_valid_ff || rsp_ready) begin
               out_valid_in = 1'b1;
               out_pos_x_in = pos_x_ff;
               out_pos_y_in = pos_y_ff;
               out_vel_x_in = vel_x_ff;
               out_vel_y_in = vel_y_ff;
               state_in     = asps_pkg::S_IDLE;
            end
         end
         default: state_in = asps_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= asps_pkg::S_IDLE;
         wait_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
         pos_x_ff     <= 32'(RST_ARENA_W >> 1);
         pos_y_ff     <= 32'(RST_ARENA_H >> 1);
         vel_x_ff     <= '0;
         vel_y_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         wait_ff      <= wait_in;
         out_valid_ff <= out_valid_in;
         pos_x_ff     <= pos_x_in;
         pos_y_ff     <= pos_y_in;
         vel_x_ff     <= vel_x_in;
         vel_y_ff     <= vel_y_in;
      end
      tgt_x_ff <= tgt_x_in;
      tgt_y_ff <= tgt_y_in;
      vx_ff    <= vx_in;
      vy_ff    <= vy_in;
      dx_ff    <= dx_in;
      dy_ff    <= dy_in;
      st_x_ff  <= st_x_in;
      st_y_ff  <= st_y_in;
      sum_ff   <= sum_in;
      prod_ff  <= prod_in;
      len_ff   <= len_in;
      speed_ff <= speed_in;
      phase_ff <= phase_in;
      out_pos_x_ff <= out_pos_x_in;
      out_pos_y_ff <= out_pos_y_in;
      out_vel_x_ff <= out_vel_x_in;
      out_vel_y_ff <= out_vel_y_in;
   end

   assign req_ready = (state_ff == asps_pkg::S_IDLE);
   assign rsp_valid = out_valid_ff;
   assign rsp_pos_x = out_pos_x_ff;
   assign rsp_pos_y = out_pos_y_ff;
   assign rsp_vel_x = out_vel_x_ff;
   assign rsp_vel_y = out_vel_y_ff;

   `ASSERT_CLK(a_done_expected, clock, reset, alu_rsp.done |-> wait_ff, "unexpected unit result")
   `ASSERT_CLK(a_start_waits, clock, reset, alu_req.start |=> wait_ff, "unit start not tracked")
   `ASSERT_CLK(a_accept_busy, clock, reset, (req_valid && req_ready) |=> !req_ready, "took two items")
   `ASSERT_CLK(a_rsp_hold, clock, reset, (rsp_valid && !rsp_ready) |=> rsp_valid, "result dropped")

endmodule
